>>> rtl/joint_distance_error_stats_top_macros.svh
// Assertion macros for the port-level checker of the joint distance statistics block.
`ifndef JOINT_DISTANCE_ERROR_STATS_TOP_MACROS_SVH
`define JOINT_DISTANCE_ERROR_STATS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JDES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define JDES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/jdes_pkg.sv
// Types and fixed constants of the joint distance statistics block.
`timescale 1ns / 1ps

package jdes_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned ABS_W    = 16;
  localparam int unsigned DIST_W   = 17;
  localparam int unsigned SUM_W    = 24;
  localparam int unsigned IDX_W    = 6;
  localparam int unsigned SQ_W     = 34;
  localparam int unsigned SQ_STEPS = ABS_W / 2;
  localparam int unsigned RT_STEPS = SQ_W / 2;
  localparam int unsigned REM_W    = DIST_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] est_x;
    logic signed [COORD_W-1:0] est_y;
    logic                      last_joint;
  } jdes_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] mean_dist;
    logic [DIST_W-1:0] max_dist;
    logic [IDX_W-1:0]  worst_index;
    logic              overflowed;
  } jdes_out_t;

  typedef enum logic [1:0] {
    DP_IDLE,
    DP_SQR,
    DP_ROOT
  } dist_phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIST,
    ST_DIV,
    ST_OUT
  } top_state_e;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] distance;
  } dist_res_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quot;
  } div_res_t;

endpackage

>>> rtl/jdes_dist.sv
// Serial Euclidean distance unit: radix-4 squarer followed by a two-bit-per-step square root.
`timescale 1ns / 1ps

module jdes_dist
  import jdes_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  jdes_in_t  pair_i,
  output dist_res_t res_o
);

  localparam int unsigned STEP_W = $clog2(RT_STEPS);

  dist_phase_e phase_q, phase_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic done_q, done_d;

  logic [ABS_W-1:0]  mx_q, mx_d, my_q, my_d;
  logic [ABS_W-1:0]  shx_q, shx_d, shy_q, shy_d;
  logic [SQ_W-1:0]   acc_q, acc_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [DIST_W-1:0] root_q, root_d;

  logic signed [COORD_W:0] dx, dy;
  logic [COORD_W:0]        ndx, ndy;
  logic [ABS_W-1:0]        ax, ay;
  logic [ABS_W+1:0]        px, py;
  logic [REM_W+1:0]        rem_sh, trial, rem_sub;

  assign dx  = {pair_i.ref_x[COORD_W-1], pair_i.ref_x} - {pair_i.est_x[COORD_W-1], pair_i.est_x};
  assign dy  = {pair_i.ref_y[COORD_W-1], pair_i.ref_y} - {pair_i.est_y[COORD_W-1], pair_i.est_y};
  assign ndx = -dx;
  assign ndy = -dy;
  assign ax  = dx[COORD_W] ? ndx[ABS_W-1:0] : dx[ABS_W-1:0];
  assign ay  = dy[COORD_W] ? ndy[ABS_W-1:0] : dy[ABS_W-1:0];

  // Partial products for the top multiplier digit of each operand.
  assign px = (shx_q[ABS_W-2] ? {2'b00, mx_q} : '0)
            + (shx_q[ABS_W-1] ? {1'b0, mx_q, 1'b0} : '0);
  assign py = (shy_q[ABS_W-2] ? {2'b00, my_q} : '0)
            + (shy_q[ABS_W-1] ? {1'b0, my_q, 1'b0} : '0);

  assign rem_sh  = {rem_q, acc_q[SQ_W-1 -: 2]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign rem_sub = rem_sh - trial;

  always_comb begin
    phase_d = phase_q;
    step_d  = step_q;
    done_d  = 1'b0;
    mx_d    = mx_q;
    my_d    = my_q;
    shx_d   = shx_q;
    shy_d   = shy_q;
    acc_d   = acc_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (phase_q)
      DP_IDLE: begin
        if (start_i) begin
          mx_d    = ax;
          my_d    = ay;
          shx_d   = ax;
          shy_d   = ay;
          acc_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          step_d  = '0;
          phase_d = DP_SQR;
        end
      end
      DP_SQR: begin
        acc_d = {acc_q[SQ_W-3:0], 2'b00} + SQ_W'(px) + SQ_W'(py);
        shx_d = {shx_q[ABS_W-3:0], 2'b00};
        shy_d = {shy_q[ABS_W-3:0], 2'b00};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(SQ_STEPS - 1)) begin
          step_d  = '0;
          phase_d = DP_ROOT;
        end
      end
      DP_ROOT: begin
        // Bring down two radicand bits, keep the trial subtraction if it fits.
        acc_d = {acc_q[SQ_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sub[REM_W-1:0];
          root_d = {root_q[DIST_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh[REM_W-1:0];
          root_d = {root_q[DIST_W-2:0], 1'b0};
        end
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(RT_STEPS - 1)) begin
          done_d  = 1'b1;
          phase_d = DP_IDLE;
        end
      end
      default: phase_d = DP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DP_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    my_q   <= my_d;
    shx_q  <= shx_d;
    shy_q  <= shy_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign res_o.done     = done_q;
  assign res_o.distance = root_q;

endmodule

>>> rtl/jdes_div.sv
// Serial restoring divider: one quotient bit per cycle for the frame mean.
`timescale 1ns / 1ps

module jdes_div
  import jdes_pkg::*;
#(
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SUM_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output div_res_t         res_o
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic busy_q, busy_d;
  logic done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W-1:0]  rem_q, rem_d;

  logic [DVS_W:0] rem_sh, rem_sub;
  logic           fits;

  assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
  assign fits    = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (busy_q) begin
      // Shift the quotient bit in where the dividend bit left.
      dvd_d  = {dvd_q[SUM_W-2:0], fits};
      rem_d  = fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      step_d = step_q + 1'b1;
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign res_o.done = done_q;
  assign res_o.quot = dvd_q;

endmodule

>>> rtl/joint_distance_error_stats_top.sv
// Top level of the joint distance statistics block: per-frame mean and maximum point error.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_stall_o  jdes_in_t  (two points, last_joint)
//   out      output     out_valid_o/out_stall_i jdes_out_t (mean, max, index, flag)
//
// A pair goes through the radix-4 squarer, then the two-bit-per-step root, then the done and
// update steps, before the next pair is accepted.
// The last pair of a frame adds serial division, then the quotient is passed on and the
// result is loaded.
// Reset clears the frame statistics and all handshake state; no clearing pass is needed.
// A result waiting under out_stall_i does not hold up the next pairs; only the next
// frame result waits for the output register to empty.
`timescale 1ns / 1ps

module joint_distance_error_stats_top
  import jdes_pkg::*;
#(
  parameter int unsigned MAX_JOINTS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  jdes_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output jdes_out_t out_data_o
);

  localparam int unsigned CNT_W = $clog2(MAX_JOINTS + 1);

  top_state_e state_q, state_d;

  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [DIST_W-1:0] max_q, max_d;
  logic [IDX_W-1:0]  worst_q, worst_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic              last_q, last_d;

  logic [DIST_W-1:0] snap_max_q, snap_max_d;
  logic [IDX_W-1:0]  snap_worst_q, snap_worst_d;
  logic              snap_ovf_q, snap_ovf_d;
  logic              snap_zero_q, snap_zero_d;

  logic      out_valid_q;
  jdes_out_t out_data_q;
  logic      out_load;

  logic      dist_start, div_start;
  dist_res_t dist_res;
  div_res_t  div_res;

  logic              room;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_nx;
  logic [DIST_W-1:0] max_nx;
  logic [IDX_W-1:0]  worst_nx;
  logic [CNT_W-1:0]  count_nx;
  logic              ovf_nx;

  assign in_stall_o = (state_q != ST_IDLE);
  assign dist_start = in_valid_i && !in_stall_o;

  jdes_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dist_start),
    .pair_i  (in_data_i),
    .res_o   (dist_res)
  );

  jdes_div #(
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_nx),
    .divisor_i  (count_nx),
    .res_o      (div_res)
  );

  // Frame statistics after folding in the distance just finished.
  assign room    = count_q < CNT_W'(MAX_JOINTS);
  assign sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(dist_res.distance);

  always_comb begin
    sum_nx   = sum_q;
    max_nx   = max_q;
    worst_nx = worst_q;
    count_nx = count_q;
    ovf_nx   = ovf_q;
    if (room) begin
      sum_nx = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
      if (dist_res.distance > max_q) begin
        max_nx   = dist_res.distance;
        worst_nx = IDX_W'(count_q);
      end
      count_nx = CNT_W'(count_q + 1'b1);
    end else begin
      ovf_nx = 1'b1;
    end
  end

  always_comb begin
    state_d      = state_q;
    sum_d        = sum_q;
    max_d        = max_q;
    worst_d      = worst_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    last_d       = last_q;
    snap_max_d   = snap_max_q;
    snap_worst_d = snap_worst_q;
    snap_ovf_d   = snap_ovf_q;
    snap_zero_d  = snap_zero_q;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          last_d  = in_data_i.last_joint;
          state_d = ST_DIST;
        end
      end
      ST_DIST: begin
        if (dist_res.done) begin
          if (last_q) begin
            // Hand the frame to the divider and clear for the next one.
            div_start    = 1'b1;
            snap_max_d   = max_nx;
            snap_worst_d = worst_nx;
            snap_ovf_d   = ovf_nx;
            snap_zero_d  = (count_nx == '0);
            sum_d        = '0;
            max_d        = '0;
            worst_d      = '0;
            count_d      = '0;
            ovf_d        = 1'b0;
            state_d      = ST_DIV;
          end else begin
            sum_d   = sum_nx;
            max_d   = max_nx;
            worst_d = worst_nx;
            count_d = count_nx;
            ovf_d   = ovf_nx;
            state_d = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      max_q       <= '0;
      worst_q     <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      max_q   <= max_d;
      worst_q <= worst_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      last_q  <= last_d;
      // Load wins over the transaction that empties the register.
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    snap_max_q   <= snap_max_d;
    snap_worst_q <= snap_worst_d;
    snap_ovf_q   <= snap_ovf_d;
    snap_zero_q  <= snap_zero_d;
    if (out_load) begin
      out_data_q.mean_dist   <= snap_zero_q ? '0 : div_res.quot[DIST_W-1:0];
      out_data_q.max_dist    <= snap_max_q;
      out_data_q.worst_index <= snap_worst_q;
      out_data_q.overflowed  <= snap_ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/jdes_checker.sv
// Port-level assertions for the joint distance statistics block, bound to its top level.
`timescale 1ns / 1ps
`include "joint_distance_error_stats_top_macros.svh"

module jdes_checker
  import jdes_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input jdes_out_t out_data_o
);

  `JDES_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed or dropped")
  `JDES_ASSERT_NOW(a_mean_le_max, out_valid_o, out_data_o.mean_dist <= out_data_o.max_dist, "mean above maximum")
  `JDES_ASSERT_NOW(a_zero_max_idx, out_valid_o && (out_data_o.max_dist == '0), out_data_o.worst_index == '0, "index set without a nonzero maximum")
  `JDES_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o, "input taken while a pair is in flight")

endmodule

bind joint_distance_error_stats_top jdes_checker u_jdes_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

>>> dv/jdes_stats_checker.sv
// Checker for the joint distance statistics block: predicts frame results and compares them.
`timescale 1ns / 1ps

module jdes_stats_checker
  import jdes_pkg::*;
#(
  parameter int unsigned FRAME_CAP = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  jdes_in_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  jdes_out_t out_data_i,
  output int        mismatches_o,
  output int        pending_o
);

  localparam longint unsigned SUM_CEIL = (64'd1 << SUM_W) - 1;

  logic [SUM_W-1:0]  sum_acc;
  logic [DIST_W-1:0] peak_dist;
  logic [IDX_W-1:0]  peak_idx;
  int unsigned       pairs_taken;
  logic              spilled;
  int                errors = 0;
  jdes_out_t         frame_stats_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void clear_frame();
    sum_acc     = '0;
    peak_dist   = '0;
    peak_idx    = '0;
    pairs_taken = 0;
    spilled     = 1'b0;
  endfunction

  // Floor square root, one result bit at a time from the top.
  function automatic logic [DIST_W-1:0] pair_distance(input jdes_in_t p);
    longint            dx;
    longint            dy;
    longint unsigned   sq;
    longint unsigned   trial;
    logic [DIST_W-1:0] root;
    dx = longint'($signed(p.ref_x)) - longint'($signed(p.est_x));
    dy = longint'($signed(p.ref_y)) - longint'($signed(p.est_y));
    sq = dx * dx + dy * dy;
    root = '0;
    for (int b = DIST_W - 1; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= sq) root = trial[DIST_W-1:0];
    end
    return root;
  endfunction

  // Fold one pair into the frame; returns 1 and the frame statistics on the last pair.
  function automatic bit fold_pair(input jdes_in_t p, output jdes_out_t stats);
    logic [DIST_W-1:0] d;
    longint unsigned   total;
    d = pair_distance(p);
    if (pairs_taken < FRAME_CAP) begin
      total   = sum_acc + d;
      sum_acc = (total > SUM_CEIL) ? SUM_W'(SUM_CEIL) : SUM_W'(total);
      if (d > peak_dist) begin
        peak_dist = d;
        peak_idx  = IDX_W'(pairs_taken);
      end
      pairs_taken++;
    end else begin
      spilled = 1'b1;
    end
    if (!p.last_joint) return 1'b0;
    stats.mean_dist   = (pairs_taken != 0) ? DIST_W'(sum_acc / pairs_taken) : '0;
    stats.max_dist    = peak_dist;
    stats.worst_index = peak_idx;
    stats.overflowed  = spilled;
    clear_frame();
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    jdes_out_t stats;
    jdes_out_t want;
    if (!rst_ni) begin
      clear_frame();
      frame_stats_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (fold_pair(in_data_i, stats)) frame_stats_q.push_back(stats);
      end
      if (out_valid_i && !out_stall_i) begin
        if (frame_stats_q.size() == 0) begin
          report_mismatch($sformatf("result with no frame pending: %p", out_data_i));
        end else begin
          want = frame_stats_q.pop_front();
          if (out_data_i.mean_dist !== want.mean_dist)
            report_mismatch($sformatf("mean_dist got %0d want %0d",
                                      out_data_i.mean_dist, want.mean_dist));
          if (out_data_i.max_dist !== want.max_dist)
            report_mismatch($sformatf("max_dist got %0d want %0d",
                                      out_data_i.max_dist, want.max_dist));
          if (out_data_i.worst_index !== want.worst_index)
            report_mismatch($sformatf("worst_index got %0d want %0d",
                                      out_data_i.worst_index, want.worst_index));
          if (out_data_i.overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %0b want %0b",
                                      out_data_i.overflowed, want.overflowed));
        end
      end
    end
    pending_o    <= frame_stats_q.size();
    mismatches_o <= errors;
  end

endmodule

>>> dv/tb_joint_distance_error_stats_top.sv
// Testbench top for the joint distance statistics block: frame stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb_joint_distance_error_stats_top;
  import jdes_pkg::*;

  localparam int unsigned FRAME_CAP    = 64;
  localparam real         HALF_PERIOD  = 6.0;
  localparam int          QUIET_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          PHASE_PAIRS  = 295;

  typedef enum int {
    SHAPE_WIDE,
    SHAPE_NEAR,
    SHAPE_SAME,
    SHAPE_CORNER,
    SHAPE_REPEAT
  } pair_shape_e;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  jdes_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  jdes_out_t out_data;
  int        mismatches;
  int        pending;
  int        gap_pct   = 17;
  int        stall_pct = 63;
  int        quiet_cycles = 0;

  joint_distance_error_stats_top #(
    .MAX_JOINTS (FRAME_CAP)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  jdes_stats_checker #(
    .FRAME_CAP (FRAME_CAP)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort when no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("joint_distance_error_stats_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Hold valid across back-to-back transactions; drop it only for an idle gap.
  task automatic drive_pair(input jdes_in_t p);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic jdes_in_t pts(input int rx, input int ry, input int ex, input int ey,
                                   input bit last);
    jdes_in_t p;
    p.ref_x      = COORD_W'(rx);
    p.ref_y      = COORD_W'(ry);
    p.est_x      = COORD_W'(ex);
    p.est_y      = COORD_W'(ey);
    p.last_joint = last;
    return p;
  endfunction

  function automatic logic [COORD_W-1:0] corner_coord();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'hffff;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic jdes_in_t random_pair(input bit last, input jdes_in_t prior);
    jdes_in_t    p;
    pair_shape_e shape;
    shape   = pair_shape_e'($urandom_range(SHAPE_REPEAT));
    p.ref_x = COORD_W'($urandom);
    p.ref_y = COORD_W'($urandom);
    p.est_x = COORD_W'($urandom);
    p.est_y = COORD_W'($urandom);
    case (shape)
      SHAPE_NEAR: begin
        p.est_x = p.ref_x + COORD_W'($urandom_range(127)) - COORD_W'(64);
        p.est_y = p.ref_y + COORD_W'($urandom_range(127)) - COORD_W'(64);
      end
      SHAPE_SAME: begin
        p.est_x = p.ref_x;
        p.est_y = p.ref_y;
      end
      SHAPE_CORNER: begin
        p.ref_x = corner_coord();
        p.ref_y = corner_coord();
        p.est_x = corner_coord();
        p.est_y = corner_coord();
      end
      SHAPE_REPEAT: p = prior;
      default: ;
    endcase
    p.last_joint = last;
    return p;
  endfunction

  // Mostly short frames; a few run up to and past capacity.
  task automatic run_phase(input int sender_pct, input int receiver_pct);
    int       sent;
    int       len;
    int       roll;
    jdes_in_t p;
    gap_pct   = sender_pct;
    stall_pct = receiver_pct;
    sent      = 0;
    p         = '0;
    while (sent < PHASE_PAIRS) begin
      roll = $urandom_range(99);
      if (roll < 80) len = $urandom_range(8, 1);
      else if (roll < 90) len = $urandom_range(30, 9);
      else len = $urandom_range(FRAME_CAP + 8, FRAME_CAP - 1);
      for (int j = 0; j < len; j++) begin
        p = random_pair(j == len - 1, p);
        drive_pair(p);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // widest possible spans
    drive_pair(pts(-32768, -32768, 32767, 32767, 1'b1));
    drive_pair(pts(32767, 32767, -32768, -32768, 1'b0));
    drive_pair(pts(-32768, 32767, 32767, -32768, 1'b1));
    // all-zero distances keep index 0
    drive_pair(pts(0, 0, 0, 0, 1'b0));
    drive_pair(pts(-1, -1, -1, -1, 1'b0));
    drive_pair(pts(32767, -32768, 32767, -32768, 1'b1));
    // equal maxima: the earlier joint wins
    drive_pair(pts(0, 0, 48, 64, 1'b0));
    drive_pair(pts(10, 10, 58, 74, 1'b0));
    drive_pair(pts(0, 0, 3, 4, 1'b0));
    drive_pair(pts(-20, -20, 28, 44, 1'b1));
    // rising maximum, then a tie, with non-square sums
    drive_pair(pts(0, 0, 1, 1, 1'b0));
    drive_pair(pts(0, 0, 0, -2, 1'b0));
    drive_pair(pts(5, 5, 5, 3, 1'b0));
    drive_pair(pts(7, -7, 0, 0, 1'b0));
    drive_pair(pts(0, 0, 9, 0, 1'b1));
    drive_pair(pts(100, -100, -100, 100, 1'b1));

    run_phase(17, 63);
    run_phase(63, 17);
    run_phase(0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("joint_distance_error_stats_top verification clean");
    end else begin
      $display("joint_distance_error_stats_top verification failed");
    end
    $finish;
  end

endmodule
